/* src/cellular_automaton_hash_unit_assert.svh */
// Assertion macros shared by the cellular automaton hash unit.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef CELLULAR_AUTOMATON_HASH_UNIT_ASSERT_SVH
`define CELLULAR_AUTOMATON_HASH_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CAH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CAH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cah_pkg.sv */
// Package for the cellular automaton hash unit: sizes, payload and queue types,
// register indexes and the fold and automaton step functions. No dependencies.
package cah_pkg;

  // Ring size; at least 64 so the bit count fits in the low cells
  localparam int unsigned CELLS      = 256;
  localparam int unsigned POS_W      = $clog2(CELLS);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 64;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NUM_WORDS  = 4;
  localparam int unsigned WIDX_W     = 2;
  localparam int unsigned RULE_W     = 8;
  localparam int unsigned GEN_W      = 12;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_ADDR_W = 2;
  // Queue depth between front and back; a power of two
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_ADDR_W-1:0] REG_CA_RULE   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_GEN_COUNT = CFG_ADDR_W'(1);

  localparam logic [RULE_W-1:0] CA_RULE_RST   = RULE_W'(30);
  localparam logic [GEN_W-1:0]  GEN_COUNT_RST = GEN_W'(128);
  localparam logic [WIDX_W-1:0] LAST_WIDX     = WIDX_W'(NUM_WORDS - 1);

  typedef logic [CELLS-1:0] ring_t;

  typedef struct packed {
    logic               end_of_message;
    logic [BYTE_W-1:0]  msg_byte;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  hash_word;
    logic [WIDX_W-1:0]  word_index;
    logic               last_word;
  } out_item_t;

  typedef enum logic {
    KIND_DATA,
    KIND_LAST
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  msg_byte;
  } entry_t;

  // Head of the front queue as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

  typedef struct packed {
    logic [RULE_W-1:0] ca_rule;
    logic [GEN_W-1:0]  gen_count;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_FOLD,
    ST_RUN,
    ST_EMIT
  } back_state_e;

  // Wrap a position that is below twice the ring size
  function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W:0] p);
    logic [POS_W:0] r;
    r = p;
    if (r >= (POS_W+1)'(CELLS)) r = r - (POS_W+1)'(CELLS);
    return r[POS_W-1:0];
  endfunction

  // XOR one byte into the ring, MSB first, from position pos upward
  function automatic ring_t fold_byte(input ring_t c, input logic [POS_W-1:0] pos,
                                      input logic [BYTE_W-1:0] b);
    ring_t          r;
    logic [POS_W-1:0] p;
    r = c;
    for (int j = 0; j < BYTE_W; j++) begin
      p = wrap_pos({1'b0, pos} + (POS_W+1)'(j));
      r[p] = r[p] ^ b[BYTE_W-1-j];
    end
    return r;
  endfunction

  // One generation of the circular elementary automaton
  function automatic ring_t ca_step(input ring_t c, input logic [RULE_W-1:0] rule);
    ring_t       r;
    logic [2:0]  nb;
    for (int i = 0; i < CELLS; i++) begin
      nb = {c[(i + CELLS - 1) % CELLS], c[i], c[(i + 1) % CELLS]};
      r[i] = rule[nb];
    end
    return r;
  endfunction

endpackage

/* src/cah_front.sv */
// Front end of the cellular automaton hash unit: accepts bytes, tags the
// final one of a message and queues them for the back end. Uses cah_pkg.
`include "cellular_automaton_hash_unit_assert.svh"

module cah_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cah_pkg::in_item_t item_i,
  output logic              full_o,
  output cah_pkg::qhead_t   head_o,
  input  logic              take_i
);
  import cah_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] count_q;
  logic              wr_en, rd_en;
  entry_t            entry_in;

  assign full_o = (count_q == QCNT_W'(QDEPTH));
  assign wr_en  = push_i && !full_o;
  assign rd_en  = take_i && head_o.valid;

  // Classify the incoming byte
  assign entry_in.kind     = item_i.end_of_message ? KIND_LAST : KIND_DATA;
  assign entry_in.msg_byte = item_i.msg_byte;

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_q];

  // Store the beat at the tail
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= entry_in;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      if (wr_en && !rd_en)      count_q <= count_q + 1'b1;
      else if (rd_en && !wr_en) count_q <= count_q - 1'b1;
    end
  end

  `CAH_ASSERT_NOW(a_cnt_bound, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue overfilled")
  `CAH_ASSERT_NOW(a_ptr_track, 1'b1, (rd_q + count_q[QPTR_W-1:0]) == wr_q,
                  "queue pointers disagree with occupancy")
  `CAH_ASSERT_NEXT(a_cnt_inc, wr_en && !rd_en, count_q == $past(count_q) + 1'b1,
                   "occupancy missed a write")

endmodule

/* src/cah_back.sv */
// Back end of the cellular automaton hash unit: folds queued bytes into the
// ring, runs the automaton and presents the four hash words. Uses cah_pkg.
`include "cellular_automaton_hash_unit_assert.svh"

module cah_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cah_pkg::cfg_t      cfg_i,
  input  cah_pkg::qhead_t    head_i,
  output logic               take_o,
  output logic               empty_o,
  output cah_pkg::out_item_t result_o,
  input  logic               pop_i
);
  import cah_pkg::*;

  back_state_e       state_q, state_d;
  ring_t             cells_q, cells_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [GEN_W-1:0]  gen_q, gen_d;
  logic [WIDX_W-1:0] word_q, word_d;
  logic              fold_en, out_done;
  ring_t             folded;
  logic [NUM_WORDS-1:0][WORD_W-1:0] words;

  assign fold_en  = (state_q == ST_FOLD) && head_i.valid;
  assign out_done = (state_q == ST_EMIT) && pop_i && (word_q == LAST_WIDX);
  assign cnt_inc  = cnt_q + CNT_W'(BYTE_W);
  assign folded   = fold_byte(cells_q, pos_q, head_i.entry.msg_byte);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FOLD: begin
        if (fold_en && head_i.entry.kind == KIND_LAST) begin
          state_d = (cfg_i.gen_count == '0) ? ST_EMIT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (gen_q == GEN_W'(1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_done) state_d = ST_FOLD;
      end
      default: state_d = ST_FOLD;
    endcase
  end

  // Datapath updates
  always_comb begin
    cells_d = cells_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    gen_d   = gen_q;
    word_d  = word_q;
    case (state_q)
      ST_FOLD: begin
        if (fold_en) begin
          cells_d = folded;
          cnt_d   = cnt_inc;
          pos_d   = wrap_pos({1'b0, pos_q} + (POS_W+1)'(BYTE_W));
          if (head_i.entry.kind == KIND_LAST) begin
            cells_d[CNT_W-1:0] = folded[CNT_W-1:0] ^ cnt_inc;
            gen_d              = cfg_i.gen_count;
          end
        end
      end
      ST_RUN: begin
        cells_d = ca_step(cells_q, cfg_i.ca_rule);
        gen_d   = gen_q - 1'b1;
      end
      ST_EMIT: begin
        if (pop_i) begin
          word_d = word_q + 1'b1;
          if (out_done) begin
            cells_d = '0;
            cnt_d   = '0;
            pos_d   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Slice the ring into output words, cells past the ring read as zero
  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
    for (genvar k = 0; k < WORD_W; k++) begin : g_bit
      if (w * WORD_W + k < CELLS) begin : g_cell
        assign words[w][k] = cells_q[w * WORD_W + k];
      end else begin : g_pad
        assign words[w][k] = 1'b0;
      end
    end
  end

  // Outputs
  always_comb begin
    take_o              = (state_q == ST_FOLD);
    empty_o             = (state_q != ST_EMIT);
    result_o.hash_word  = words[word_q];
    result_o.word_index = word_q;
    result_o.last_word  = (word_q == LAST_WIDX);
  end

  // Hold or advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FOLD;
      cells_q <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      gen_q   <= '0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      cells_q <= cells_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      gen_q   <= gen_d;
      word_q  <= word_d;
    end
  end

  `CAH_ASSERT_NOW(a_word_idle, state_q != ST_EMIT, word_q == '0,
                  "word index left non-zero outside output phase")
  `CAH_ASSERT_NEXT(a_gen_dec, state_q == ST_RUN, gen_q == $past(gen_q) - 1'b1,
                   "generation count did not step down")
  `CAH_ASSERT_NEXT(a_clear, out_done, state_q == ST_FOLD && cnt_q == '0 && pos_q == '0,
                   "ring not cleared after the last word")

endmodule

/* src/cellular_automaton_hash_unit.sv */
// Cellular automaton hash unit, top level: configuration registers, front
// queue and back end. Uses cah_pkg, cah_front and cah_back.
//
// Usage: message bytes enter on a queue-style port (push/full), one beat per
// byte, end_of_message set on the final byte. Bytes go into a 4-entry queue;
// the back end folds one byte per cycle, while in its fold phase with a byte
// queued, into a 256-cell ring. After a final byte the bit count is XORed into
// cells 0 to 63 and the automaton runs generation_count generations, one
// generation per cycle. The hash then appears as four beats on the result
// side (empty/pop), word_index 0 to 3, with last_word on the fourth; each beat
// waits until popped, and the ring and counter clear once the fourth goes.
// The fold, the automaton and the output share the single ring register, so
// bytes of the next message are only folded once the fourth word of this one
// is popped. While the result side stalls, the queue keeps taking up to four
// bytes of the next message, then full rises. Reset clears the ring, the
// counter, the queue, and loads ca_rule 30 and generation_count 128. Write the
// registers only while the unit is idle.
module cellular_automaton_hash_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cah_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [cah_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  cah_pkg::in_item_t               item_i,
  output logic                            empty,
  input  logic                            pop,
  output cah_pkg::out_item_t              result_o
);
  import cah_pkg::*;

  cfg_t   cfg_q;
  qhead_t head;
  logic   take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ca_rule   <= CA_RULE_RST;
      cfg_q.gen_count <= GEN_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_CA_RULE:   cfg_q.ca_rule   <= cfg_wdata_i[RULE_W-1:0];
        REG_GEN_COUNT: cfg_q.gen_count <= cfg_wdata_i[GEN_W-1:0];
        default: ;
      endcase
    end
  end

  cah_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item_i),
    .full_o (full),
    .head_o (head),
    .take_i (take)
  );

  cah_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .head_i   (head),
    .take_o   (take),
    .empty_o  (empty),
    .result_o (result_o),
    .pop_i    (pop)
  );

endmodule
